@@ design/wsclock_page_replacement_top_macros.svh @@
// Assertion macros used by the page replacement top level.
`ifndef WSCLOCK_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define WSCLOCK_PAGE_REPLACEMENT_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define WSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`define WSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WSC_ASSERT(label, prop, msg)
`define WSC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ design/wsc_pkg.sv @@
// Types and constants of the WSClock page replacement block.
package wsc_pkg;

    localparam int FRAMES     = 64;
    localparam int FRAME_W    = $clog2(FRAMES);
    localparam int CNT_W      = $clog2(FRAMES + 1);
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
    localparam int TIME_W     = 32;
    localparam int TOTAL_W    = 32;
    localparam int WR_W       = 7;
    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 3;

    localparam logic REG_FRAMES = 1'b0;
    localparam logic REG_TAU    = 1'b1;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FREE  = 2'd1,
        OUT_CLEAN = 2'd2,
        OUT_DIRTY = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SWEEP,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              is_write;
    } t_in;

    typedef struct packed {
        t_outcome           outcome;
        logic [FRAME_W-1:0] frame_slot;
        logic [WR_W-1:0]    writes_this_access;
        logic [TOTAL_W-1:0] fault_total;
        logic [TOTAL_W-1:0] write_total;
    } t_out;

    // Verdict of the frame evaluation unit on the frame just read.
    typedef struct packed {
        logic              page_eq;
        logic              age_gt;
        logic              older;
        logic [TIME_W-1:0] cand;
    } t_eval;

endpackage

@@ design/wsc_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module wsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/wsc_cmp.sv @@
// Shared frame evaluation unit: page match, age test and oldest-time compare.
module wsc_cmp
    import wsc_pkg::*;
(
    input  logic [PAGE_W-1:0] i_page,
    input  logic [PAGE_W-1:0] i_frame_page,
    input  logic [TIME_W-1:0] i_now,
    input  logic [TIME_W-1:0] i_frame_time,
    input  logic [TIME_W-1:0] i_tau,
    input  logic              i_ref,
    input  logic [TIME_W:0]   i_oldest,
    output t_eval             o_eval
);

    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] cand;

    // A referenced frame is re-timed before it takes part in the oldest search.
    assign cand = i_ref ? i_now : i_frame_time;
    assign age  = i_now - i_frame_time;

    always_comb begin
        o_eval.page_eq = (i_page == i_frame_page);
        o_eval.age_gt  = (age > i_tau);
        o_eval.older   = ({1'b0, cand} < i_oldest);
        o_eval.cand    = cand;
    end

endmodule

@@ design/wsclock_page_replacement_top.sv @@
// Top level of the WSClock page replacement block: sequencer, frame state and APB registers.
// An access walks the frames from slot 0 for a hit; a fault fills the next free frame or,
// when none is free, sweeps the frames from the clock hand for a victim.
// One access at a time: the walk and the sweep read one frame per cycle, and busy drops in
// the cycle that shows the result beat, so a new access is taken only from that cycle on.
// Reset is synchronous and active low; it empties the table and clears all totals.
`include "wsclock_page_replacement_top_macros.svh"

module wsclock_page_replacement_top
    import wsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  t_in                i_item,
    output logic               busy,
    output logic               o_valid,
    output t_out               o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_n;
    logic [TIME_W-1:0]   r_tau;
    logic [FRAMES-1:0]   r_valid, r_dirty, r_ref;
    logic [FRAME_W-1:0]  r_hand, r_fill;
    logic [CNT_W-1:0]    r_free;
    logic [TIME_W-1:0]   r_access;
    logic [TOTAL_W-1:0]  r_fault, r_wtot;
    logic [PAGE_W-1:0]   r_page;
    logic                r_wr;
    logic [TIME_W-1:0]   r_now;
    logic [FRAME_W-1:0]  r_ih, r_pidx, r_cnt, r_slot;
    logic                r_pend, r_evict;
    logic [TIME_W:0]     r_oldest;
    logic [WR_W-1:0]     r_writes;
    logic                r_out_valid;
    t_out                r_out;

    logic                accept, cfg_we;
    logic [CNT_W-1:0]    cfg_n;
    logic [TIME_W-1:0]   now_next;
    logic [PAGE_W-1:0]   page_rdata;
    logic [TIME_W-1:0]   time_rdata;
    t_eval               eval;
    logic                cnt_last, hit, s_ref, s_dirty, s_take;
    logic [FRAME_W-1:0]  ih_next, pidx_next, fill_next;
    logic                time_we, page_we;
    logic [FRAME_W-1:0]  time_waddr;
    logic                evict_dirty;
    logic [WR_W-1:0]     writes_fin;
    logic [TOTAL_W-1:0]  fault_next, wtot_next;
    logic [TOTAL_W:0]    wsum;
    t_outcome            commit_outcome;

    function automatic logic [FRAME_W-1:0] wrap_inc(input logic [FRAME_W-1:0] idx,
                                                    input logic [CNT_W-1:0] n);
        wrap_inc = ((CNT_W'(idx) + CNT_W'(1)) == n) ? '0 : idx + FRAME_W'(1);
    endfunction

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign o_valid = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        cfg_n = pwdata[CNT_W-1:0];
        if (cfg_n == '0) begin
            cfg_n = CNT_W'(1);
        end else if (cfg_n > CNT_W'(FRAMES)) begin
            cfg_n = CNT_W'(FRAMES);
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FRAMES: prdata = DATA_W'(r_n);
            REG_TAU:    prdata = r_tau;
            default:    prdata = '0;
        endcase
    end

    assign now_next = (r_access == '1) ? r_access : r_access + TIME_W'(1);

    wsc_ram #(.WIDTH(PAGE_W), .DEPTH(FRAMES)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (page_we),
        .i_waddr (r_slot),
        .i_wdata (r_page),
        .i_raddr (r_ih),
        .o_rdata (page_rdata)
    );

    wsc_ram #(.WIDTH(TIME_W), .DEPTH(FRAMES)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (time_waddr),
        .i_wdata (r_now),
        .i_raddr (r_ih),
        .o_rdata (time_rdata)
    );

    wsc_cmp u_cmp (
        .i_page       (r_page),
        .i_frame_page (page_rdata),
        .i_now        (r_now),
        .i_frame_time (time_rdata),
        .i_tau        (r_tau),
        .i_ref        (r_ref[r_pidx]),
        .i_oldest     (r_oldest),
        .o_eval       (eval)
    );

    assign cnt_last  = (CNT_W'(r_cnt) == (r_n - CNT_W'(1)));
    assign ih_next   = wrap_inc(r_ih, r_n);
    assign pidx_next = wrap_inc(r_pidx, r_n);
    assign fill_next = wrap_inc(r_fill, r_n);
    assign s_ref     = r_ref[r_pidx];
    assign s_dirty   = r_dirty[r_pidx];
    assign s_take    = !s_ref && !s_dirty && eval.age_gt;
    assign hit       = (r_state == ST_LOOK) && r_pend && r_valid[r_pidx] && eval.page_eq;

    assign evict_dirty = r_evict && r_dirty[r_slot];
    assign writes_fin  = r_writes + WR_W'(evict_dirty);
    assign fault_next  = (r_fault == '1) ? r_fault : r_fault + TOTAL_W'(1);
    assign wsum        = {1'b0, r_wtot} + (TOTAL_W + 1)'(writes_fin);
    assign wtot_next   = wsum[TOTAL_W] ? '1 : wsum[TOTAL_W-1:0];

    always_comb begin
        priority if (!r_evict) begin
            commit_outcome = OUT_FREE;
        end else if (evict_dirty) begin
            commit_outcome = OUT_DIRTY;
        end else begin
            commit_outcome = OUT_CLEAN;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                if (hit) begin
                    n_state = ST_IDLE;
                end else if (r_pend && cnt_last) begin
                    n_state = (r_free != '0) ? ST_COMMIT : ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (r_pend && (s_take || cnt_last)) n_state = ST_COMMIT;
            end
            ST_COMMIT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Memory write controls. Every time written is the current access time.
    always_comb begin
        time_we    = 1'b0;
        time_waddr = r_pidx;
        page_we    = 1'b0;
        unique case (r_state)
            ST_IDLE:  ;
            ST_LOOK:  time_we = hit;
            ST_SWEEP: time_we = r_pend && s_ref;
            ST_COMMIT: begin
                time_we    = 1'b1;
                time_waddr = r_slot;
                page_we    = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_n         <= CNT_W'(FRAMES);
            r_tau       <= '0;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_ref       <= '0;
            r_hand      <= '0;
            r_fill      <= '0;
            r_free      <= CNT_W'(FRAMES);
            r_access    <= '0;
            r_fault     <= '0;
            r_wtot      <= '0;
            r_pend      <= 1'b0;
            r_evict     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_page   <= i_item.address[ADDR_W-1:PAGE_SHIFT];
                        r_wr     <= i_item.is_write;
                        r_now    <= now_next;
                        r_access <= now_next;
                        r_ih     <= '0;
                        r_cnt    <= '0;
                        r_pend   <= 1'b0;
                    end
                end
                ST_LOOK: begin
                    r_pend <= 1'b1;
                    r_pidx <= r_ih;
                    r_ih   <= ih_next;
                    if (r_pend) r_cnt <= r_cnt + FRAME_W'(1);
                    if (hit) begin
                        r_ref[r_pidx] <= 1'b1;
                        if (r_wr) r_dirty[r_pidx] <= 1'b1;
                        r_out_valid                 <= 1'b1;
                        r_out.outcome               <= OUT_HIT;
                        r_out.frame_slot            <= r_pidx;
                        r_out.writes_this_access    <= '0;
                        r_out.fault_total           <= r_fault;
                        r_out.write_total           <= r_wtot;
                    end else if (r_pend && cnt_last) begin
                        r_writes <= '0;
                        if (r_free != '0) begin
                            r_slot  <= r_fill;
                            r_fill  <= fill_next;
                            r_free  <= r_free - CNT_W'(1);
                            r_evict <= 1'b0;
                        end else begin
                            // Restart the read pipeline at the clock hand for the sweep.
                            r_ih     <= r_hand;
                            r_pend   <= 1'b0;
                            r_cnt    <= '0;
                            r_oldest <= {1'b1, {TIME_W{1'b0}}};
                            r_slot   <= '0;
                            r_evict  <= 1'b1;
                        end
                    end
                end
                ST_SWEEP: begin
                    r_pend <= 1'b1;
                    r_pidx <= r_ih;
                    r_ih   <= ih_next;
                    if (r_pend) begin
                        r_cnt <= r_cnt + FRAME_W'(1);
                        priority if (s_ref) begin
                            r_ref[r_pidx] <= 1'b0;
                        end else if (s_dirty) begin
                            r_dirty[r_pidx] <= 1'b0;
                            r_writes        <= r_writes + WR_W'(1);
                        end
                        if (s_take) begin
                            r_slot <= r_pidx;
                            r_hand <= pidx_next;
                        end else begin
                            if (eval.older) begin
                                r_oldest <= {1'b0, eval.cand};
                                r_slot   <= r_pidx;
                            end
                            if (cnt_last) r_hand <= pidx_next;
                        end
                    end
                end
                ST_COMMIT: begin
                    r_valid[r_slot]          <= 1'b1;
                    r_dirty[r_slot]          <= r_wr;
                    r_ref[r_slot]            <= 1'b1;
                    r_fault                  <= fault_next;
                    r_wtot                   <= wtot_next;
                    r_out_valid              <= 1'b1;
                    r_out.outcome            <= commit_outcome;
                    r_out.frame_slot         <= r_slot;
                    r_out.writes_this_access <= writes_fin;
                    r_out.fault_total        <= fault_next;
                    r_out.write_total        <= wtot_next;
                end
                default: ;
            endcase

            // Register writes must arrive only while idle (unchecked); a new frame count flushes the table.
            if (cfg_we) begin
                unique case (paddr[2])
                    REG_FRAMES: begin
                        r_n     <= cfg_n;
                        r_free  <= cfg_n;
                        r_valid <= '0;
                        r_dirty <= '0;
                        r_ref   <= '0;
                        r_hand  <= '0;
                        r_fill  <= '0;
                    end
                    REG_TAU: r_tau <= pwdata[TIME_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    `WSC_ASSERT(a_result_after_work, o_valid |-> ($past(r_state) != ST_IDLE), "result beat without work")
    `WSC_ASSERT_NEXT(a_start_walks, start && !busy, r_state == ST_LOOK, "accepted access did not start the walk")
    `WSC_ASSERT(a_sweep_only_full, (r_state == ST_SWEEP) |-> (r_free == '0), "sweep with free frames left")
    `WSC_ASSERT(a_free_bounded, r_free <= r_n, "free count above frame count")
    `WSC_ASSERT(a_pointers_bounded, (CNT_W'(r_fill) < r_n) && (CNT_W'(r_hand) < r_n), "pointer beyond frame count")

endmodule

@@ test/tb_wsclock_page_replacement_top.sv @@
// Testbench for the WSClock page replacement block: directed and random accesses against a predictor.
`timescale 1ns / 1ps

module tb_wsclock_page_replacement_top;
    import wsc_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_FRAMES_IN_USE = PADDR_W'(4 * int'(REG_FRAMES));
    localparam logic [PADDR_W-1:0] ADDR_TAU           = PADDR_W'(4 * int'(REG_TAU));
    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    t_in               i_item;
    logic              busy;
    logic              o_valid;
    t_out              o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Mirror of the frame table and the counters.
    logic [PAGE_W-1:0] tbl_page [FRAMES];
    bit                tbl_valid [FRAMES];
    bit                tbl_dirty [FRAMES];
    bit                tbl_ref [FRAMES];
    logic [TIME_W-1:0] tbl_time [FRAMES];
    int unsigned       hand_pos;
    int unsigned       fill_pos;
    int unsigned       free_frames;
    int unsigned       frames_cfg;
    logic [TIME_W-1:0] tau_cfg;
    logic [TIME_W-1:0] access_cnt;
    logic [TOTAL_W-1:0] fault_cnt;
    logic [TOTAL_W-1:0] wb_cnt;

    t_out pending_results[$];
    bit   failed = 1'b0;
    bit   gaps_on = 1'b1;

    wsclock_page_replacement_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic void flush_table();
        for (int i = 0; i < FRAMES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_dirty[i] = 1'b0;
            tbl_ref[i]   = 1'b0;
        end
        hand_pos    = 0;
        fill_pos    = 0;
        free_frames = frames_cfg;
    endfunction

    function automatic void set_frame_count(input logic [DATA_W-1:0] value);
        int unsigned c;
        c = value[6:0];
        if (c == 0) c = 1;
        if (c > FRAMES) c = FRAMES;
        frames_cfg = c;
        flush_table();
    endfunction

    // Applies one access to the mirrored table and returns the result it must produce.
    function automatic t_out replace_page(input t_in acc);
        t_out              res;
        logic [PAGE_W-1:0] page;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] age;
        logic [TIME_W:0]   oldest;
        int unsigned       n;
        int unsigned       h;
        int unsigned       victim;
        int unsigned       slot;
        int unsigned       wb;
        bit                hit;
        bit                found;
        n    = frames_cfg;
        page = acc.address[ADDR_W-1:PAGE_SHIFT];
        now  = sat_add(access_cnt, 1);
        hit  = 1'b0;
        slot = 0;
        wb   = 0;
        for (int i = 0; i < n && !hit; i++) begin
            if (tbl_valid[i] && tbl_page[i] == page) begin
                hit  = 1'b1;
                slot = i;
            end
        end
        if (hit) begin
            tbl_ref[slot]  = 1'b1;
            tbl_time[slot] = now;
            if (acc.is_write) tbl_dirty[slot] = 1'b1;
            res.outcome = OUT_HIT;
        end else begin
            if (free_frames > 0) begin
                slot = fill_pos % n;
                free_frames--;
                fill_pos = (slot + 1) % n;
                res.outcome = OUT_FREE;
            end else begin
                oldest = 33'h1_0000_0000;
                victim = 0;
                h      = hand_pos % n;
                found  = 1'b0;
                for (int cnt = 0; cnt < n && !found; cnt++) begin
                    age = now - tbl_time[h];
                    if (tbl_ref[h]) begin
                        tbl_ref[h]  = 1'b0;
                        tbl_time[h] = now;
                    end else if (tbl_dirty[h]) begin
                        wb++;
                        tbl_dirty[h] = 1'b0;
                    end else if (age > tau_cfg) begin
                        victim = h;
                        found  = 1'b1;
                    end
                    // Without an old clean frame the victim is the oldest one seen.
                    if (!found && {1'b0, tbl_time[h]} < oldest) begin
                        oldest = {1'b0, tbl_time[h]};
                        victim = h;
                    end
                    h = (h + 1) % n;
                end
                hand_pos = h;
                slot     = victim;
                if (tbl_dirty[victim]) begin
                    wb++;
                    res.outcome = OUT_DIRTY;
                end else begin
                    res.outcome = OUT_CLEAN;
                end
            end
            tbl_page[slot]  = page;
            tbl_valid[slot] = 1'b1;
            tbl_dirty[slot] = acc.is_write;
            tbl_ref[slot]   = 1'b1;
            tbl_time[slot]  = now;
            fault_cnt = sat_add(fault_cnt, 1);
            wb_cnt    = sat_add(wb_cnt, wb);
        end
        access_cnt = now;
        res.frame_slot         = FRAME_W'(slot);
        res.writes_this_access = (wb > 127) ? WR_W'(127) : WR_W'(wb);
        res.fault_total        = fault_cnt;
        res.write_total        = wb_cnt;
        return res;
    endfunction

    function automatic t_in access_of(input logic [ADDR_W-1:0] a, input logic w);
        t_in acc;
        acc.address  = a;
        acc.is_write = w;
        return acc;
    endfunction

    task automatic apb_write_reg(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] readback;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_FRAMES_IN_USE) set_frame_count(data);
        else if (addr == ADDR_TAU) tau_cfg = data;
        @(negedge i_clk);
        // The register just written must read back at the same address.
        readback = (addr == ADDR_TAU) ? tau_cfg : DATA_W'(frames_cfg);
        if (prdata !== readback) begin
            $error("prdata: expected %0d, actual %0d", readback, prdata);
            failed = 1'b1;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Presents one access and waits for its beat to be taken; start stays high afterward.
    task automatic send_access(input t_in acc);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2 * frames_cfg + 8)) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= acc;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(replace_page(acc));
    endtask

    task automatic drain_accesses();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no access outstanding");
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (o_result.outcome !== want.outcome) begin
                    $error("outcome: expected %0d, actual %0d", want.outcome, o_result.outcome);
                    failed = 1'b1;
                end
                if (o_result.frame_slot !== want.frame_slot) begin
                    $error("frame_slot: expected %0d, actual %0d",
                           want.frame_slot, o_result.frame_slot);
                    failed = 1'b1;
                end
                if (o_result.writes_this_access !== want.writes_this_access) begin
                    $error("writes_this_access: expected %0d, actual %0d",
                           want.writes_this_access, o_result.writes_this_access);
                    failed = 1'b1;
                end
                if (o_result.fault_total !== want.fault_total) begin
                    $error("fault_total: expected %0d, actual %0d",
                           want.fault_total, o_result.fault_total);
                    failed = 1'b1;
                end
                if (o_result.write_total !== want.write_total) begin
                    $error("write_total: expected %0d, actual %0d",
                           want.write_total, o_result.write_total);
                    failed = 1'b1;
                end
            end
        end
    end

    // Empty table with the reset frame count: fills in order and hits at both page extremes.
    task automatic test_fill_and_hit();
        send_access(access_of(32'h0000_0000, ACC_READ));
        send_access(access_of(32'hFFFF_FFFF, ACC_WRITE));
        send_access(access_of(32'h0000_0FFF, ACC_READ));
        send_access(access_of(32'hFFFF_F000, ACC_WRITE));
        send_access(access_of(32'h8000_1234, ACC_WRITE));
        drain_accesses();
    endtask

    // A frame count of zero acts as one, so after the first fill every miss sweeps the single frame.
    task automatic test_single_frame();
        apb_write_reg(ADDR_FRAMES_IN_USE, 32'd0);
        send_access(access_of(32'h0000_1000, ACC_READ));
        send_access(access_of(32'h0000_2000, ACC_WRITE));
        send_access(access_of(32'h0000_3000, ACC_READ));
        drain_accesses();
    endtask

    // Counts above the built size clamp; with the largest tau only the oldest frame is evicted.
    task automatic test_oldest_eviction();
        apb_write_reg(ADDR_FRAMES_IN_USE, 32'd127);
        apb_write_reg(ADDR_FRAMES_IN_USE, 32'd65);
        apb_write_reg(ADDR_FRAMES_IN_USE, 32'd2);
        apb_write_reg(ADDR_TAU, 32'hFFFF_FFFF);
        send_access(access_of(32'h0000_A000, ACC_WRITE));
        send_access(access_of(32'h0000_B000, ACC_WRITE));
        send_access(access_of(32'h0000_C000, ACC_READ));
        send_access(access_of(32'h0000_D000, ACC_READ));
        send_access(access_of(32'h0000_C004, ACC_WRITE));
        send_access(access_of(32'h0000_E000, ACC_READ));
        drain_accesses();
    endtask

    // With tau at zero any unreferenced clean frame is old enough; tau of one is stricter.
    task automatic test_age_limit();
        apb_write_reg(ADDR_FRAMES_IN_USE, 32'd3);
        apb_write_reg(ADDR_TAU, 32'd0);
        send_access(access_of(32'h0000_1000, ACC_READ));
        send_access(access_of(32'h0000_2000, ACC_WRITE));
        send_access(access_of(32'h0000_3000, ACC_READ));
        send_access(access_of(32'h0000_1010, ACC_READ));
        send_access(access_of(32'h0000_4000, ACC_READ));
        send_access(access_of(32'h0000_5000, ACC_WRITE));
        drain_accesses();
        apb_write_reg(ADDR_TAU, 32'd1);
        send_access(access_of(32'h0000_6000, ACC_READ));
        send_access(access_of(32'h0000_2020, ACC_WRITE));
        drain_accesses();
    endtask

    // Phases of random accesses over a small page set per phase, so hits and sweeps both occur.
    task automatic test_random_mix();
        int unsigned       frame_list[12] = '{4, 1, 2, 8, 3, 64, 16, 0, 5, 100, 2, 7};
        logic [PAGE_W-1:0] pages[$];
        logic [PAGE_W-1:0] page;
        int unsigned       beats;
        for (int p = 0; p < 12; p++) begin
            drain_accesses();
            gaps_on = !(p == 5 || p == 6);
            // Every fourth phase keeps the table and only moves tau.
            if (p % 4 != 3)
                apb_write_reg(ADDR_FRAMES_IN_USE, ($urandom & ~32'h7F) | frame_list[p]);
            case (p % 3)
                0: apb_write_reg(ADDR_TAU, 32'd0);
                1: apb_write_reg(ADDR_TAU, (p == 10) ? $urandom : $urandom_range(1, 3 * frames_cfg));
                default: apb_write_reg(ADDR_TAU, 32'hFFFF_FFFF);
            endcase
            pages.delete();
            repeat (frames_cfg + $urandom_range(1, frames_cfg) + 1) pages.push_back(PAGE_W'($urandom));
            beats = (frames_cfg >= FRAMES) ? 140 : 60;
            repeat (beats) begin
                if ($urandom_range(0, 99) < 85) page = pages[$urandom_range(0, pages.size() - 1)];
                else page = PAGE_W'($urandom);
                send_access(access_of({page, 12'($urandom)}, 1'($urandom_range(0, 1))));
            end
        end
        gaps_on = 1'b1;
        drain_accesses();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        frames_cfg = FRAMES;
        tau_cfg    = '0;
        access_cnt = '0;
        fault_cnt  = '0;
        wb_cnt     = '0;
        for (int i = 0; i < FRAMES; i++) begin
            tbl_page[i] = '0;
            tbl_time[i] = '0;
        end
        flush_table();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_and_hit();
        test_single_frame();
        test_oldest_eviction();
        test_age_limit();
        test_random_mix();

        repeat (2 * FRAMES + 8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/wsc_pkg.sv
design/wsc_ram.sv
design/wsc_cmp.sv
design/wsclock_page_replacement_top.sv
test/tb_wsclock_page_replacement_top.sv
